[rtl/sipl_pkg.sv]
`default_nettype none
package sipl_pkg;

	localparam int unsigned CMD_W     = 2;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned COUNT_W   = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic do_insert;
		logic do_remove;
	} cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/sipl_req_if.sv]
`default_nettype none
interface sipl_req_if;
	logic                          valid;
	logic                          ready;
	logic [sipl_pkg::CMD_W-1:0]    command;
	logic signed [sipl_pkg::DATA_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

[rtl/sipl_rsp_if.sv]
`default_nettype none
interface sipl_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [sipl_pkg::DATA_W-1:0] smallest;
	logic [sipl_pkg::COUNT_W-1:0]       count;
	logic                               empty_res;
	logic                               error;

	modport source (output valid, output smallest, output count, output empty_res,
		output error, input ready);
	modport sink   (input valid, input smallest, input count, input empty_res,
		input error, output ready);
endinterface
`default_nettype wire

[rtl/sorted_insert_priority_list_top.sv]
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one item per cycle; every cell compares and shifts in parallel,
//   so the only stall is a result register still holding an untaken result.
// Reset (arst_n low): count cleared, result register emptied; stored values
//   are not reset and are only read below the count.
`default_nettype none
module sorted_insert_priority_list_top #(
	parameter int unsigned CAPACITY   = 16,
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sipl_req_if.sink    req,
	sipl_rsp_if.source  rsp
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	// Chain wiring: cell i sees its left (i-1) and right (i+1) neighbor.
	logic [VALUE_BITS-1:0] cell_val [CAPACITY];
	logic [VALUE_BITS-1:0] cell_nxt [CAPACITY];
	logic                  cell_gt  [CAPACITY];

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic [VALUE_BITS-1:0] ins_val;
	logic                  accept;
	logic                  full;
	logic                  err;
	sipl_pkg::cell_ctrl_t  ctrl;
	sipl_pkg::cmd_t        cmd;

	// result register
	logic                                rsp_valid_q;
	logic signed [sipl_pkg::DATA_W-1:0]  smallest_q;
	logic [sipl_pkg::COUNT_W-1:0]        count_out_q;
	logic                                empty_q;
	logic                                error_q;

	logic [VALUE_BITS+sipl_pkg::DATA_W-1:0] ins_ext;
	logic [VALUE_BITS+sipl_pkg::DATA_W-1:0] front_ext;
	logic [CNT_W+sipl_pkg::COUNT_W-1:0]     count_ext;

	// A new transfer is taken whenever the result slot is free or being drained.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign cmd       = sipl_pkg::cmd_t'(req.command);
	assign full      = count_q == CNT_W'(CAPACITY);

	// Input value: sign-extend, then keep the low VALUE_BITS bits.
	assign ins_ext = {{VALUE_BITS{req.value[sipl_pkg::DATA_W-1]}}, req.value};
	assign ins_val = ins_ext[VALUE_BITS-1:0];

	always_comb begin
		ctrl      = '0;
		count_nxt = count_q;
		err       = 1'b0;
		if (accept) begin
			unique case (cmd)
				sipl_pkg::CMD_INSERT: begin
					if (full) begin
						err = 1'b1;            // value dropped
					end else begin
						ctrl.do_insert = 1'b1;
						count_nxt      = count_q + 1'b1;
					end
				end
				sipl_pkg::CMD_REMOVE: begin
					if (count_q == '0) begin
						err = 1'b1;
					end else begin
						ctrl.do_remove = 1'b1;
						count_nxt      = count_q - 1'b1;
					end
				end
				sipl_pkg::CMD_CLEAR: count_nxt = '0;
				sipl_pkg::CMD_NOP:   count_nxt = count_q;
				default:             count_nxt = count_q;
			endcase
		end
	end

	// Row of compare-and-shift cells; slot 0 always holds the smallest value.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sipl_cell #(
			.IDX        (i),
			.CNT_W      (CNT_W),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.ins_val   (ins_val),
			.left_val  ((i == 0) ? ins_val : cell_val[(i == 0) ? 0 : i-1]),
			.left_gt   ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i-1]),
			.right_val ((i == CAPACITY-1) ? cell_val[i]
				: cell_val[(i == CAPACITY-1) ? i : i+1]),
			.val       (cell_val[i]),
			.gt        (cell_gt[i]),
			.nxt       (cell_nxt[i])
		);
	end

	// Front value of the updated store, sign-extended to the output width.
	assign front_ext = {{sipl_pkg::DATA_W{cell_nxt[0][VALUE_BITS-1]}}, cell_nxt[0]};
	assign count_ext = {{sipl_pkg::COUNT_W{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept)         rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smallest_q  <= (count_nxt == '0) ? '0 : front_ext[sipl_pkg::DATA_W-1:0];
			count_out_q <= count_ext[sipl_pkg::COUNT_W-1:0];
			empty_q     <= count_nxt == '0;
			error_q     <= err;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.smallest  = smallest_q;
	assign rsp.count     = count_out_q;
	assign rsp.empty_res = empty_q;
	assign rsp.error     = error_q;

	// ---------------------------------------------------------------- checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.command == sipl_pkg::CMD_CLEAR |=> rsp.valid && rsp.empty_res && !rsp.error)
		else $error("clear did not empty the list");

	a_full_insert_err: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && req.command == sipl_pkg::CMD_INSERT |=> rsp.error && count_q == $past(count_q))
		else $error("insert into full list not flagged");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.empty_res |-> rsp.smallest == '0)
		else $error("empty list shows a nonzero front");

endmodule
`default_nettype wire

[rtl/sipl_cell.sv]
`default_nettype none
module sipl_cell #(
	parameter int unsigned IDX        = 0,
	parameter int unsigned CNT_W      = 5,
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic                   clk,
	input  wire sipl_pkg::cell_ctrl_t   ctrl,
	input  wire logic [CNT_W-1:0]       count,
	input  wire logic [VALUE_BITS-1:0]  ins_val,
	input  wire logic [VALUE_BITS-1:0]  left_val,
	input  wire logic                   left_gt,
	input  wire logic [VALUE_BITS-1:0]  right_val,
	output logic [VALUE_BITS-1:0]       val,
	output logic                        gt,
	output logic [VALUE_BITS-1:0]       nxt
);

	logic [VALUE_BITS-1:0] val_q;
	logic                  live;

	// unused slots count as greater, so the first free slot takes the new value
	assign live = count > CNT_W'(IDX);
	assign gt   = !live || ($signed(val_q) > $signed(ins_val));
	assign val  = val_q;

	always_comb begin
		priority if (ctrl.do_insert) begin
			if (gt) nxt = left_gt ? left_val : ins_val;
			else    nxt = val_q;
		end else if (ctrl.do_remove) begin
			nxt = right_val;
		end else begin
			nxt = val_q;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= nxt;
	end

endmodule
`default_nettype wire
